// ===== hdl/eps_pkg.sv =====
`default_nettype none
package eps_pkg;

  localparam int PART_CNT = 64;
  localparam int PORT_CNT = 256;
  localparam int PART_AW = (PART_CNT > 1) ? $clog2(PART_CNT) : 1;
  localparam int PORT_AW = (PORT_CNT > 1) ? $clog2(PORT_CNT) : 1;
  localparam int PART_GRP = (PART_CNT + 15) / 16;
  localparam int PORT_GRP = (PORT_CNT + 15) / 16;
  localparam int GLB_W = 14;
  localparam int LOC_W = 4;
  localparam int PART_W = 4;
  localparam int PORT_W = 13;
  localparam int SWP_W = 9;

  localparam logic [1:0] REQ_SET  = 2'd0;
  localparam logic [1:0] REQ_TEST = 2'd1;
  localparam logic [1:0] REQ_NEXT = 2'd2;

  localparam logic [1:0] CLS_GLB  = 2'd0;
  localparam logic [1:0] CLS_PART = 2'd1;
  localparam logic [1:0] CLS_PORT = 2'd2;
  localparam logic [1:0] CLS_NONE = 2'd3;

  localparam logic [4:0] EV_PART_BASE = 5'd14;

  typedef struct packed {
    logic [1:0] req_type;
    logic [4:0] event_id;
    logic [7:0] index;
    logic       index_all;
    logic       index_local;
  } eps_in_t;

  typedef struct packed {
    logic       status;
    logic       hit;
    logic       found;
    logic [4:0] found_event;
    logic [7:0] found_index;
  } eps_out_t;

  typedef struct packed {
    logic               part_any;
    logic [PART_AW-1:0] part_idx;
    logic               port_any;
    logic [PORT_AW-1:0] port_idx;
  } eps_scan_t;

  function automatic logic [1:0] ev_class(input logic [4:0] ev);
    logic [1:0] c;
    if (ev <= 5'd13) c = CLS_GLB;
    else if (ev <= 5'd17) c = CLS_PART;
    else if (ev <= 5'd29) c = CLS_PORT;
    else c = CLS_NONE;
    return c;
  endfunction

  function automatic logic [3:0] ev_bit(input logic [4:0] ev);
    logic [4:0] b;
    if (ev <= 5'd13) b = ev;
    else if (ev <= 5'd17) b = ev - 5'd14;
    else if (ev <= 5'd21) b = ev - 5'd18;
    else if (ev <= 5'd29) b = ev - 5'd17;
    else b = 5'd0;
    return b[3:0];
  endfunction

  function automatic logic [4:0] port_bit_to_event(input logic [3:0] b);
    logic [4:0] e;
    if (b < 4'd4) e = 5'd18 + {1'b0, b};
    else e = 5'd17 + {1'b0, b};
    return e;
  endfunction

  // index of the lowest set bit, 0 when none
  function automatic logic [3:0] lowest16(input logic [15:0] v);
    logic [3:0] b;
    b = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (v[i]) b = 4'(i);
    end
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/eps_ram.sv =====
`default_nettype none
module eps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hdl/eps_scan.sv =====
`default_nettype none
module eps_scan
  import eps_pkg::*;
(
  input  wire logic                clk,
  input  wire logic [PART_CNT-1:0] part_flags,
  input  wire logic [PORT_CNT-1:0] port_flags,
  output eps_scan_t                res
);

  logic [PART_GRP*16-1:0] part_pad;
  logic [PORT_GRP*16-1:0] port_pad;
  logic [PART_GRP-1:0]    part_gany_r;
  logic [3:0]             part_glow_r [PART_GRP];
  logic [PORT_GRP-1:0]    port_gany_r;
  logic [3:0]             port_glow_r [PORT_GRP];
  logic [3:0]             part_g;
  logic [3:0]             port_g;
  logic [7:0]             part_full;
  logic [7:0]             port_full;
  eps_scan_t              res_nxt;

  assign part_pad = (PART_GRP*16)'(part_flags);
  assign port_pad = (PORT_GRP*16)'(port_flags);

  // first stage: one lowest-flag encoder per group of sixteen entries
  always_ff @(posedge clk) begin
    for (int g = 0; g < PART_GRP; g++) begin
      part_gany_r[g] <= |part_pad[g*16 +: 16];
      part_glow_r[g] <= lowest16(part_pad[g*16 +: 16]);
    end
    for (int g = 0; g < PORT_GRP; g++) begin
      port_gany_r[g] <= |port_pad[g*16 +: 16];
      port_glow_r[g] <= lowest16(port_pad[g*16 +: 16]);
    end
  end

  // second stage: pick the lowest non-empty group
  always_comb begin
    part_g = lowest16(16'(part_gany_r));
    port_g = lowest16(16'(port_gany_r));
    part_full = {part_g, part_glow_r[part_g[$clog2(PART_GRP+1)-1:0] % PART_GRP]};
    port_full = {port_g, port_glow_r[port_g[$clog2(PORT_GRP+1)-1:0] % PORT_GRP]};
    res_nxt.part_any = |part_gany_r;
    res_nxt.part_idx = part_full[PART_AW-1:0];
    res_nxt.port_any = |port_gany_r;
    res_nxt.port_idx = port_full[PORT_AW-1:0];
  end

  always_ff @(posedge clk) begin
    res <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/event_pending_summary_store_unit.sv =====
`default_nettype none
// Channel   Ports                      Handshake
// request   in_req                     start, taken when busy is low
// result    out_res                    out_valid, one cycle, no backpressure
//
// Set and test on a partition or port word pass through decode, memory read
// and, for a set, write back. Global and local requests finish in decode. A
// next request that misses the global word runs the two-stage flag scan,
// then the read-modify-write, or ends after the scan when nothing is pending
// at all. A set to every partition or port sweeps its memory, one entry a
// cycle. Reset clears the non-empty flags, which stand in for a cleared
// memory; no clearing pass is needed. Results cannot be stalled.
module event_pending_summary_store_unit
  import eps_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire eps_in_t in_req,
  output logic      out_valid,
  output eps_out_t  out_res
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RMW   = 3'd2;
  localparam logic [2:0] S_SWEEP = 3'd3;
  localparam logic [2:0] S_SCANW = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;

  logic [2:0]         state_r, state_nxt;
  eps_in_t            req_r, req_nxt;
  logic               sel_port_r, sel_port_nxt;
  logic [7:0]         addr_r, addr_nxt;
  logic [SWP_W-1:0]   cnt_r, cnt_nxt;
  logic               swp_pend_r, swp_pend_nxt;
  logic [7:0]         swp_addr_r, swp_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  eps_out_t           out_r, out_nxt;
  logic [GLB_W-1:0]   glb_r, glb_nxt;
  logic [LOC_W-1:0]   loc_r, loc_nxt;
  logic [PART_CNT-1:0] part_flag_r;
  logic [PORT_CNT-1:0] port_flag_r;

  logic               part_we, part_re, port_we, port_re;
  logic [PART_AW-1:0] part_waddr, part_raddr;
  logic [PORT_AW-1:0] port_waddr, port_raddr;
  logic [PART_W-1:0]  part_wdata, part_rdata;
  logic [PORT_W-1:0]  port_wdata, port_rdata;
  eps_scan_t          scan;

  logic [1:0]  cls;
  logic [3:0]  bitpos;
  logic [15:0] mask16;
  logic        part_ok, port_ok;
  logic [7:0]  cur_addr;
  logic [15:0] rd16, new16;
  logic [3:0]  low_b;
  logic [3:0]  glb_b;

  eps_ram #(.WIDTH(PART_W), .DEPTH(PART_CNT)) u_part_ram (
    .clk(clk), .we(part_we), .waddr(part_waddr), .wdata(part_wdata),
    .re(part_re), .raddr(part_raddr), .rdata(part_rdata)
  );

  eps_ram #(.WIDTH(PORT_W), .DEPTH(PORT_CNT)) u_port_ram (
    .clk(clk), .we(port_we), .waddr(port_waddr), .wdata(port_wdata),
    .re(port_re), .raddr(port_raddr), .rdata(port_rdata)
  );

  eps_scan u_scan (
    .clk(clk), .part_flags(part_flag_r), .port_flags(port_flag_r), .res(scan)
  );

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  always_comb begin
    cls     = ev_class(req_r.event_id);
    bitpos  = ev_bit(req_r.event_id);
    mask16  = 16'(1) << bitpos;
    part_ok = {1'b0, req_r.index} < 9'(PART_CNT);
    port_ok = {1'b0, req_r.index} < 9'(PORT_CNT);
    glb_b   = lowest16(16'(glb_r));
    // the entry whose read data arrives this cycle; a clear flag reads as zero
    cur_addr = (state_r == S_SWEEP) ? swp_addr_r : addr_r;
    if (sel_port_r)
      rd16 = port_flag_r[cur_addr[PORT_AW-1:0]] ? 16'(port_rdata) : 16'd0;
    else
      rd16 = part_flag_r[cur_addr[PART_AW-1:0]] ? 16'(part_rdata) : 16'd0;
    low_b = lowest16(rd16);
    new16 = rd16;

    state_nxt     = state_r;
    req_nxt       = req_r;
    sel_port_nxt  = sel_port_r;
    addr_nxt      = addr_r;
    cnt_nxt       = cnt_r;
    swp_pend_nxt  = 1'b0;
    swp_addr_nxt  = swp_addr_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    glb_nxt       = glb_r;
    loc_nxt       = loc_r;
    part_we = 1'b0; part_re = 1'b0; port_we = 1'b0; port_re = 1'b0;
    part_waddr = cur_addr[PART_AW-1:0];
    port_waddr = cur_addr[PORT_AW-1:0];
    part_raddr = req_r.index[PART_AW-1:0];
    port_raddr = req_r.index[PORT_AW-1:0];
    part_wdata = new16[PART_W-1:0];
    port_wdata = new16[PORT_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_nxt   = in_req;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        out_nxt      = '0;
        addr_nxt     = req_r.index;
        sel_port_nxt = (cls == CLS_PORT);
        state_nxt    = S_IDLE;
        out_valid_nxt = 1'b1;
        case (req_r.req_type)
          REQ_SET: begin
            case (cls)
              CLS_GLB: glb_nxt = glb_r | mask16[GLB_W-1:0];
              CLS_PART: begin
                if (req_r.index_local) loc_nxt = loc_r | mask16[LOC_W-1:0];
                else if (req_r.index_all) begin
                  cnt_nxt = '0; out_valid_nxt = 1'b0; state_nxt = S_SWEEP;
                end else if (part_ok) begin
                  part_re = 1'b1; out_valid_nxt = 1'b0; state_nxt = S_RMW;
                end else out_nxt.status = 1'b1;
              end
              CLS_PORT: begin
                if (req_r.index_all) begin
                  cnt_nxt = '0; out_valid_nxt = 1'b0; state_nxt = S_SWEEP;
                end else if (!req_r.index_local && port_ok) begin
                  port_re = 1'b1; out_valid_nxt = 1'b0; state_nxt = S_RMW;
                end else out_nxt.status = 1'b1;
              end
              default: ;
            endcase
          end
          REQ_TEST: begin
            case (cls)
              CLS_GLB: out_nxt.hit = |(glb_r & mask16[GLB_W-1:0]);
              CLS_PART: begin
                if (req_r.index_local) out_nxt.hit = |(loc_r & mask16[LOC_W-1:0]);
                else if (part_ok) begin
                  part_re = 1'b1; out_valid_nxt = 1'b0; state_nxt = S_RMW;
                end else out_nxt.status = 1'b1;
              end
              CLS_PORT: begin
                if (!req_r.index_local && port_ok) begin
                  port_re = 1'b1; out_valid_nxt = 1'b0; state_nxt = S_RMW;
                end else out_nxt.status = 1'b1;
              end
              default: ;
            endcase
          end
          REQ_NEXT: begin
            if (|glb_r) begin
              glb_nxt = glb_r & ~(GLB_W'(1) << glb_b);
              out_nxt.found       = 1'b1;
              out_nxt.found_event = {1'b0, glb_b};
            end else begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_SCANW;
            end
          end
          default: ;
        endcase
      end
      S_SCANW: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan.part_any) begin
          sel_port_nxt = 1'b0;
          addr_nxt     = 8'(scan.part_idx);
          part_raddr   = scan.part_idx;
          part_re      = 1'b1;
          state_nxt    = S_RMW;
        end else if (scan.port_any) begin
          sel_port_nxt = 1'b1;
          addr_nxt     = 8'(scan.port_idx);
          port_raddr   = scan.port_idx;
          port_re      = 1'b1;
          state_nxt    = S_RMW;
        end else begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_RMW: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        case (req_r.req_type)
          REQ_SET: begin
            new16 = rd16 | mask16;
            part_we = !sel_port_r; port_we = sel_port_r;
          end
          REQ_TEST: out_nxt.hit = |(rd16 & mask16);
          default: begin
            new16 = rd16 & ~(16'(1) << low_b);
            part_we = !sel_port_r; port_we = sel_port_r;
            out_nxt.found       = 1'b1;
            out_nxt.found_event = sel_port_r ? port_bit_to_event(low_b)
                                             : EV_PART_BASE + {1'b0, low_b};
            out_nxt.found_index = addr_r;
          end
        endcase
        part_wdata = new16[PART_W-1:0];
        port_wdata = new16[PORT_W-1:0];
      end
      S_SWEEP: begin
        // write back the entry read last cycle while reading the next one
        new16 = rd16 | mask16;
        part_wdata = new16[PART_W-1:0];
        port_wdata = new16[PORT_W-1:0];
        if (swp_pend_r) begin
          part_we = !sel_port_r; port_we = sel_port_r;
        end
        if (cnt_r != (sel_port_r ? SWP_W'(PORT_CNT) : SWP_W'(PART_CNT))) begin
          part_raddr   = cnt_r[PART_AW-1:0];
          port_raddr   = cnt_r[PORT_AW-1:0];
          part_re      = !sel_port_r;
          port_re      = sel_port_r;
          swp_pend_nxt = 1'b1;
          swp_addr_nxt = cnt_r[7:0];
          cnt_nxt      = cnt_r + SWP_W'(1);
        end else if (!swp_pend_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      swp_pend_r  <= 1'b0;
      glb_r       <= '0;
      loc_r       <= '0;
      part_flag_r <= '0;
      port_flag_r <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      swp_pend_r  <= swp_pend_nxt;
      glb_r       <= glb_nxt;
      loc_r       <= loc_nxt;
      if (part_we) part_flag_r[part_waddr] <= |part_wdata;
      if (port_we) port_flag_r[port_waddr] <= |port_wdata;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    sel_port_r <= sel_port_nxt;
    addr_r     <= addr_nxt;
    cnt_r      <= cnt_nxt;
    swp_addr_r <= swp_addr_nxt;
    out_r      <= out_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/eps_checker.sv =====
`default_nettype none
module eps_checker
  import eps_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire eps_out_t out_res
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result without a transaction in flight");

  a_busy_ends_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid) else $error("transaction finished without a result");

  a_err_not_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status |-> !out_res.found && !out_res.hit)
    else $error("error status with hit or found");

  a_found_no_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.found |-> !out_res.hit)
    else $error("found and hit in one result");

endmodule

bind event_pending_summary_store_unit eps_checker u_eps_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_res(out_res)
);
`default_nettype wire

// ===== bench/event_pending_summary_store_unit_tb.sv =====
`timescale 1ns / 100ps
module event_pending_summary_store_unit_tb
  import eps_pkg::*;
;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  eps_in_t in_req;
  logic out_valid;
  eps_out_t out_res;

  int cycle_cnt;
  int sender_idle_pct;

  event_pending_summary_store_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  class pending_store_scoreboard;
    logic [13:0] glb_bits;
    logic [3:0]  loc_bits;
    logic [3:0]  part_bits [PART_CNT];
    logic [12:0] port_bits [PORT_CNT];
    eps_out_t    expected_q [$];
    int          mismatch_cnt;

    function new();
      glb_bits = '0;
      loc_bits = '0;
      foreach (part_bits[i]) part_bits[i] = '0;
      foreach (port_bits[i]) port_bits[i] = '0;
      mismatch_cnt = 0;
    endfunction

    static function int first_set(input logic [15:0] w);
      for (int b = 0; b < 16; b++)
        if (w[b]) return b;
      return 0;
    endfunction

    // update the shadow store and queue the result of one transaction
    function void note_request(input eps_in_t rq);
      eps_out_t r;
      int cls;
      int bp;
      int b;
      bit part_ok;
      bit port_ok;
      r = '0;
      part_ok = rq.index < PART_CNT;
      port_ok = rq.index < PORT_CNT;
      if (rq.event_id <= 13) begin cls = 0; bp = rq.event_id; end
      else if (rq.event_id <= 17) begin cls = 1; bp = rq.event_id - 14; end
      else if (rq.event_id <= 21) begin cls = 2; bp = rq.event_id - 18; end
      else if (rq.event_id <= 29) begin cls = 2; bp = rq.event_id - 17; end
      else begin cls = 3; bp = 0; end
      case (rq.req_type)
        REQ_SET: begin
          if (cls == 0) glb_bits[bp] = 1'b1;
          else if (cls == 1) begin
            if (rq.index_local) loc_bits[bp] = 1'b1;
            else if (rq.index_all) foreach (part_bits[i]) part_bits[i][bp] = 1'b1;
            else if (part_ok) part_bits[rq.index][bp] = 1'b1;
            else r.status = 1'b1;
          end else if (cls == 2) begin
            if (rq.index_all) foreach (port_bits[i]) port_bits[i][bp] = 1'b1;
            else if (!rq.index_local && port_ok) port_bits[rq.index][bp] = 1'b1;
            else r.status = 1'b1;
          end
        end
        REQ_TEST: begin
          if (cls == 0) r.hit = glb_bits[bp];
          else if (cls == 1) begin
            if (rq.index_local) r.hit = loc_bits[bp];
            else if (part_ok) r.hit = part_bits[rq.index][bp];
            else r.status = 1'b1;
          end else if (cls == 2) begin
            if (!rq.index_local && port_ok) r.hit = port_bits[rq.index][bp];
            else r.status = 1'b1;
          end
        end
        REQ_NEXT: begin
          if (glb_bits != 0) begin
            b = first_set(16'(glb_bits));
            glb_bits[b] = 1'b0;
            r.found = 1'b1;
            r.found_event = 5'(b);
          end else begin
            for (int i = 0; i < PART_CNT && !r.found; i++)
              if (part_bits[i] != 0) begin
                b = first_set(16'(part_bits[i]));
                part_bits[i][b] = 1'b0;
                r.found = 1'b1;
                r.found_event = 5'(14 + b);
                r.found_index = 8'(i);
              end
            for (int i = 0; i < PORT_CNT && !r.found; i++)
              if (port_bits[i] != 0) begin
                b = first_set(16'(port_bits[i]));
                port_bits[i][b] = 1'b0;
                r.found = 1'b1;
                r.found_event = (b < 4) ? 5'(18 + b) : 5'(17 + b);
                r.found_index = 8'(i);
              end
          end
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    function void check_result(input eps_out_t got);
      eps_out_t exp_r;
      if (expected_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.status !== exp_r.status || got.hit !== exp_r.hit ||
          got.found !== exp_r.found || got.found_event !== exp_r.found_event ||
          got.found_index !== exp_r.found_index) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("mismatch: expected %p actual %p", exp_r, got);
      end
    endfunction
  endclass

  pending_store_scoreboard sb;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && out_valid) sb.check_result(out_res);
  end

  // drive one transaction, holding start until accepted
  task automatic issue(input eps_in_t rq);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct)
        @(posedge clk);
    end
    start <= 1'b1;
    in_req <= rq;
    do @(posedge clk); while (busy);
    sb.note_request(rq);
  endtask

  task automatic issue_fields(input logic [1:0] rt, input logic [4:0] ev,
                              input logic [7:0] idx, input logic all_f,
                              input logic loc_f);
    eps_in_t rq;
    rq.req_type = rt;
    rq.event_id = ev;
    rq.index = idx;
    rq.index_all = all_f;
    rq.index_local = loc_f;
    issue(rq);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic random_request();
    eps_in_t rq;
    int pick;
    pick = $urandom_range(99);
    rq.event_id = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) :
                  5'($urandom_range(29));
    rq.index = ($urandom_range(7) == 0) ? 8'($urandom) :
               8'($urandom_range(7) + ($urandom_range(1) ? 0 : 56));
    rq.index_all = ($urandom_range(39) == 0);
    rq.index_local = ($urandom_range(9) == 0);
    if (pick < 35) rq.req_type = REQ_SET;
    else if (pick < 60) rq.req_type = REQ_TEST;
    else if (pick < 97) rq.req_type = REQ_NEXT;
    else rq.req_type = 2'($urandom_range(3));
    issue(rq);
  endtask

  initial begin
    sb = new();
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cycle_cnt = 0;
    sender_idle_pct = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    issue_fields(REQ_NEXT, 5'd0, 8'd0, 1'b0, 1'b0);
    issue_fields(REQ_SET, 5'd13, 8'd0, 1'b1, 1'b1);
    issue_fields(REQ_SET, 5'd0, 8'd255, 1'b0, 1'b0);
    issue_fields(REQ_SET, 5'd14, 8'd63, 1'b0, 1'b0);
    issue_fields(REQ_SET, 5'd17, 8'd64, 1'b0, 1'b0);
    issue_fields(REQ_SET, 5'd15, 8'd0, 1'b1, 1'b1);
    issue_fields(REQ_SET, 5'd16, 8'd0, 1'b1, 1'b0);
    issue_fields(REQ_SET, 5'd29, 8'd255, 1'b0, 1'b0);
    issue_fields(REQ_SET, 5'd21, 8'd3, 1'b0, 1'b1);
    issue_fields(REQ_SET, 5'd22, 8'd0, 1'b1, 1'b1);
    issue_fields(REQ_SET, 5'd31, 8'd5, 1'b0, 1'b0);
    issue_fields(REQ_TEST, 5'd13, 8'd0, 1'b0, 1'b0);
    issue_fields(REQ_TEST, 5'd15, 8'd0, 1'b0, 1'b1);
    issue_fields(REQ_TEST, 5'd16, 8'd200, 1'b1, 1'b0);
    issue_fields(REQ_TEST, 5'd18, 8'd10, 1'b0, 1'b1);
    issue_fields(REQ_TEST, 5'd30, 8'd0, 1'b0, 1'b0);
    issue_fields(2'd3, 5'd31, 8'd255, 1'b1, 1'b1);
    repeat (8) issue_fields(REQ_NEXT, 5'd0, 8'd0, 1'b0, 1'b0);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: sender_idle_pct = 0;
        1: sender_idle_pct = 46;
        2: sender_idle_pct = 17;
        3: sender_idle_pct = 46;
        default: sender_idle_pct = 0;
      endcase
      for (int k = 0; k < 245; k++) random_request();
      // hold until the block has handed back everything
      wait_drained();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (sb.mismatch_cnt == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    wait (cycle_cnt >= 2000000);
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== event_pending_summary_store_unit.f =====
hdl/eps_pkg.sv
hdl/eps_ram.sv
hdl/eps_scan.sv
hdl/event_pending_summary_store_unit.sv
hdl/eps_checker.sv
bench/event_pending_summary_store_unit_tb.sv
